// ----- src/stvi_pkg.sv -----
package stvi_pkg;

	localparam int NUM_UNDERLYINGS_DEF = 8;
	localparam int MAX_STRIKES_DEF     = 32;
	localparam int UID_W               = 3;
	localparam int PRICE_W             = 32;
	localparam int VOL_W               = 32;
	localparam int TOL_W               = 16;
	localparam int SERIES              = 3;
	localparam int NUM_W               = 2 * VOL_W;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd268;

	typedef struct packed {
		logic [PRICE_W-1:0]           strike;
		logic [SERIES-1:0][VOL_W-1:0] call_vol;
		logic [SERIES-1:0][VOL_W-1:0] put_vol;
		logic [SERIES-1:0]            call_ok;
		logic [SERIES-1:0]            put_ok;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- src/stvi_ram.sv -----
module stvi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- src/stvi_div.sv -----
module stvi_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [stvi_pkg::NUM_W-1:0]   num,
	input  logic [stvi_pkg::VOL_W-1:0]   den,
	output logic                         done,
	output logic [stvi_pkg::VOL_W-1:0]   quot
);
	import stvi_pkg::*;

	localparam int CNT_W = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [VOL_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [VOL_W:0]   sh;
	logic [VOL_W:0]   diff;
	logic             ge;

	assign sh   = {rem_q, quo_q[NUM_W-1]};
	assign ge   = sh >= {1'b0, den};
	assign diff = sh - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= num;
			end else if (busy_q) begin
				rem_q <= ge ? diff[VOL_W-1:0] : sh[VOL_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q[VOL_W-1:0];
endmodule

// ----- src/strike_table_vol_interpolator_core.sv -----
// Keeps a strike-sorted table per underlying, updates it with each quote that
// has a valid series and interpolates the call/put average volatility of three
// series at the spot. A result item leaves only when some series changes
// validity or moves by more than the tolerance set on cfg_data. Items are
// processed one at a time; quote_stall is high while one is in work. An item
// scans the table for the insert position, shifts entries up on insert, scans
// for the spot bracket and then forms a weighted sum and divides it for each
// valid series, with the entry RAM (read and write ports used in turn) and the
// shared 64-step serial divider. Memories need no clearing after reset.
module strike_table_vol_interpolator_core #(
	parameter int NUM_UNDERLYINGS = stvi_pkg::NUM_UNDERLYINGS_DEF,
	parameter int MAX_STRIKES     = stvi_pkg::MAX_STRIKES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          quote_valid,
	output logic                          quote_stall,
	input  logic [stvi_pkg::UID_W-1:0]    underlying_id,
	input  logic                          is_call,
	input  logic [stvi_pkg::PRICE_W-1:0]  strike_price,
	input  logic [stvi_pkg::PRICE_W-1:0]  spot_price,
	input  logic [stvi_pkg::VOL_W-1:0]    vol_first,
	input  logic                          vol_first_ok,
	input  logic [stvi_pkg::VOL_W-1:0]    vol_second,
	input  logic                          vol_second_ok,
	input  logic [stvi_pkg::VOL_W-1:0]    vol_third,
	input  logic                          vol_third_ok,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [stvi_pkg::UID_W-1:0]    out_underlying,
	output logic [stvi_pkg::VOL_W-1:0]    index_first,
	output logic                          index_first_ok,
	output logic [stvi_pkg::VOL_W-1:0]    index_second,
	output logic                          index_second_ok,
	output logic [stvi_pkg::VOL_W-1:0]    index_third,
	output logic                          index_third_ok,
	output logic [stvi_pkg::PRICE_W-1:0]  out_spot,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [stvi_pkg::TOL_W-1:0]    cfg_data
);
	import stvi_pkg::*;

	localparam int DEPTH  = NUM_UNDERLYINGS * MAX_STRIKES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int UIX_W  = (NUM_UNDERLYINGS > 1) ? $clog2(NUM_UNDERLYINGS) : 1;
	localparam int CNT_W  = $clog2(MAX_STRIKES + 1);
	localparam int IX_W   = $clog2(MAX_STRIKES);

	typedef enum logic [15:0] {
		ST_IDLE     = 16'b0000_0000_0000_0001,
		ST_SRCH_RD  = 16'b0000_0000_0000_0010,
		ST_SRCH_CMP = 16'b0000_0000_0000_0100,
		ST_SHIFT_RD = 16'b0000_0000_0000_1000,
		ST_SHIFT_WR = 16'b0000_0000_0001_0000,
		ST_WRITE    = 16'b0000_0000_0010_0000,
		ST_SPOT_RD  = 16'b0000_0000_0100_0000,
		ST_SPOT_CMP = 16'b0000_0000_1000_0000,
		ST_LOAD_LO  = 16'b0000_0001_0000_0000,
		ST_MUL_HI   = 16'b0000_0010_0000_0000,
		ST_MUL_LO   = 16'b0000_0100_0000_0000,
		ST_ACC      = 16'b0000_1000_0000_0000,
		ST_DIV_GO   = 16'b0001_0000_0000_0000,
		ST_DIV      = 16'b0010_0000_0000_0000,
		ST_UPDATE   = 16'b0100_0000_0000_0000,
		ST_EMIT     = 16'b1000_0000_0000_0000
	} state_t;

	state_t                      state_q;
	logic [UID_W-1:0]            u_q;
	logic                        call_q;
	logic [PRICE_W-1:0]          strike_q;
	logic [PRICE_W-1:0]          spot_q;
	logic [SERIES-1:0][VOL_W-1:0] vol_q;
	logic [SERIES-1:0]           vok_q;
	logic [CNT_W-1:0]            cnt_q [NUM_UNDERLYINGS];
	logic [CNT_W-1:0]            n_q;
	logic [CNT_W-1:0]            i_q;
	logic [CNT_W-1:0]            pos_q;
	logic                        match_q;
	logic                        first_q;
	entry_t                      ent_q;
	entry_t                      lo_q;
	logic [PRICE_W-1:0]          span_q;
	logic [PRICE_W-1:0]          dhi_q;
	logic [PRICE_W-1:0]          dlo_q;
	logic [1:0]                  k_q;
	logic [NUM_W-1:0]            prod_q;
	logic [NUM_W-1:0]            acc_q;
	logic [SERIES-1:0][VOL_W-1:0] idx_q;
	logic [SERIES-1:0]           iok_q;
	logic [SERIES-1:0][VOL_W-1:0] prev_q [NUM_UNDERLYINGS];
	logic [SERIES-1:0]           pok_q [NUM_UNDERLYINGS];
	logic [TOL_W-1:0]            tol_q;
	logic                        res_valid_q;
	logic [UID_W-1:0]            res_u_q;
	logic [SERIES-1:0][VOL_W-1:0] res_idx_q;
	logic [SERIES-1:0]           res_ok_q;
	logic [PRICE_W-1:0]          res_spot_q;

	logic [UIX_W-1:0]            uix;
	logic [ADDR_W-1:0]           base;
	logic                        re;
	logic                        we;
	logic [IX_W-1:0]             rix;
	logic [IX_W-1:0]             wix;
	entry_t                      wdata;
	entry_t                      rd;
	entry_t                      merged;
	logic [CNT_W-1:0]            i_m1;
	logic [CNT_W-1:0]            i_p1;
	logic [VOL_W-1:0]            avg_hi;
	logic [VOL_W-1:0]            avg_lo;
	logic [VOL_W:0]              sum_hi;
	logic [VOL_W:0]              sum_lo;
	logic                        ser_ok;
	logic [VOL_W-1:0]            mul_a;
	logic [PRICE_W-1:0]          mul_b;
	logic                        div_start;
	logic                        div_done;
	logic [VOL_W-1:0]            quot;
	logic [SERIES-1:0]           chg;
	logic                        out_free;

	assign uix  = UIX_W'(u_q);
	assign base = ADDR_W'(uix) * ADDR_W'(MAX_STRIKES);
	assign i_m1 = i_q - 1'b1;
	assign i_p1 = i_q + 1'b1;
	assign out_free = !res_valid_q || !result_stall;

	stvi_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(base + ADDR_W'(wix)),
		.wdata(wdata),
		.re   (re),
		.raddr(base + ADDR_W'(rix)),
		.rdata(rd)
	);

	stvi_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (acc_q),
		.den   (span_q),
		.done  (div_done),
		.quot  (quot)
	);

	assign div_start = (state_q == ST_DIV_GO);

	// entry written for the quote: matched entry or a fresh one, then its side
	always_comb begin
		merged = match_q ? ent_q : '0;
		merged.strike = strike_q;
		for (int k = 0; k < SERIES; k++) begin
			if (call_q) begin
				merged.call_vol[k] = vok_q[k] ? vol_q[k] : '0;
				merged.call_ok[k]  = vok_q[k];
			end else begin
				merged.put_vol[k] = vok_q[k] ? vol_q[k] : '0;
				merged.put_ok[k]  = vok_q[k];
			end
		end
	end

	always_comb begin
		re    = 1'b0;
		we    = 1'b0;
		rix   = i_q[IX_W-1:0];
		wix   = i_q[IX_W-1:0];
		wdata = rd;
		case (state_q)
			ST_SRCH_RD, ST_SPOT_RD: begin
				re = 1'b1;
			end
			ST_SHIFT_RD: begin
				re  = 1'b1;
				rix = i_m1[IX_W-1:0];
			end
			ST_SPOT_CMP: begin
				re  = 1'b1;
				rix = i_m1[IX_W-1:0];
			end
			ST_SHIFT_WR: begin
				we = 1'b1;
			end
			ST_WRITE: begin
				we    = 1'b1;
				wix   = pos_q[IX_W-1:0];
				wdata = merged;
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	always_comb begin
		sum_hi = {1'b0, ent_q.call_vol[k_q]} + {1'b0, ent_q.put_vol[k_q]};
		sum_lo = {1'b0, lo_q.call_vol[k_q]} + {1'b0, lo_q.put_vol[k_q]};
		avg_hi = sum_hi[VOL_W:1];
		avg_lo = sum_lo[VOL_W:1];
		ser_ok = ent_q.call_ok[k_q] && ent_q.put_ok[k_q] && lo_q.call_ok[k_q] && lo_q.put_ok[k_q];
		mul_a  = (state_q == ST_MUL_HI) ? avg_hi : avg_lo;
		mul_b  = (state_q == ST_MUL_HI) ? dhi_q : dlo_q;
	end

	always_comb begin
		for (int k = 0; k < SERIES; k++) begin
			logic [VOL_W-1:0] p;
			logic [VOL_W-1:0] d;
			p = prev_q[uix][k];
			d = (p > idx_q[k]) ? (p - idx_q[k]) : (idx_q[k] - p);
			if (pok_q[uix][k] != iok_q[k]) begin
				chg[k] = 1'b1;
			end else begin
				chg[k] = iok_q[k] && (d > VOL_W'(tol_q));
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= NUM_W'(mul_a) * NUM_W'(mul_b);
		if (state_q == ST_UPDATE) begin
			for (int k = 0; k < SERIES; k++) begin
				if (chg[k]) begin
					prev_q[uix][k] <= idx_q[k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tol_q       <= TOL_RESET;
			res_valid_q <= 1'b0;
			for (int j = 0; j < NUM_UNDERLYINGS; j++) begin
				cnt_q[j] <= '0;
				pok_q[j] <= '0;
			end
			u_q <= '0; call_q <= 1'b0; strike_q <= '0; spot_q <= '0;
			vol_q <= '0; vok_q <= '0; n_q <= '0; i_q <= '0; pos_q <= '0;
			match_q <= 1'b0; first_q <= 1'b0; ent_q <= '0; lo_q <= '0;
			span_q <= '0; dhi_q <= '0; dlo_q <= '0; k_q <= '0; acc_q <= '0;
			idx_q <= '0; iok_q <= '0; res_u_q <= '0; res_idx_q <= '0;
			res_ok_q <= '0; res_spot_q <= '0;
		end else begin
			if (cfg_valid) begin
				tol_q <= cfg_data;
			end
			if (res_valid_q && !result_stall && state_q != ST_EMIT) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (quote_valid) begin
						u_q      <= underlying_id;
						call_q   <= is_call;
						strike_q <= strike_price;
						spot_q   <= spot_price;
						vol_q    <= {vol_third, vol_second, vol_first};
						vok_q    <= {vol_third_ok, vol_second_ok, vol_first_ok};
						match_q  <= 1'b0;
						pos_q    <= '0;
						i_q      <= '0;
						n_q      <= cnt_q[UIX_W'(underlying_id)];
						first_q  <= (cnt_q[UIX_W'(underlying_id)] == '0);
						if (int'(underlying_id) < NUM_UNDERLYINGS &&
							(vol_first_ok || vol_second_ok || vol_third_ok)) begin
							state_q <= (cnt_q[UIX_W'(underlying_id)] == '0) ?
								ST_WRITE : ST_SRCH_RD;
						end
					end
				end
				ST_SRCH_RD: begin
					state_q <= ST_SRCH_CMP;
				end
				ST_SRCH_CMP: begin
					if (rd.strike < strike_q && i_p1 != n_q) begin
						i_q     <= i_p1;
						state_q <= ST_SRCH_RD;
					end else begin
						ent_q   <= rd;
						pos_q   <= (rd.strike < strike_q) ? n_q : i_q;
						match_q <= (rd.strike == strike_q);
						if (rd.strike == strike_q) begin
							state_q <= ST_WRITE;
						end else if (n_q < CNT_W'(MAX_STRIKES)) begin
							i_q     <= n_q;
							state_q <= (rd.strike < strike_q) ? ST_WRITE : ST_SHIFT_RD;
						end else begin
							i_q     <= '0;
							state_q <= ST_SPOT_RD;
						end
					end
				end
				ST_SHIFT_RD: begin
					state_q <= ST_SHIFT_WR;
				end
				ST_SHIFT_WR: begin
					i_q     <= i_m1;
					state_q <= (i_m1 > pos_q) ? ST_SHIFT_RD : ST_WRITE;
				end
				ST_WRITE: begin
					if (!match_q) begin
						cnt_q[uix] <= n_q + 1'b1;
						n_q        <= n_q + 1'b1;
					end
					i_q     <= '0;
					state_q <= first_q ? ST_IDLE : ST_SPOT_RD;
				end
				ST_SPOT_RD: begin
					state_q <= ST_SPOT_CMP;
				end
				ST_SPOT_CMP: begin
					if (rd.strike < spot_q) begin
						i_q     <= i_p1;
						state_q <= (i_p1 == n_q) ? ST_IDLE : ST_SPOT_RD;
					end else if (i_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						ent_q   <= rd;
						state_q <= ST_LOAD_LO;
					end
				end
				ST_LOAD_LO: begin
					lo_q    <= rd;
					span_q  <= ent_q.strike - rd.strike;
					dhi_q   <= spot_q - rd.strike;
					dlo_q   <= ent_q.strike - spot_q;
					k_q     <= '0;
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					if (ser_ok) begin
						state_q <= ST_MUL_LO;
					end else begin
						idx_q[k_q] <= '0;
						iok_q[k_q] <= 1'b0;
						k_q        <= k_q + 1'b1;
						state_q    <= (k_q == 2'(SERIES - 1)) ? ST_UPDATE : ST_MUL_HI;
					end
				end
				ST_MUL_LO: begin
					acc_q   <= prod_q + NUM_W'(span_q[PRICE_W-1:1]);
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q   <= acc_q + prod_q;
					state_q <= ST_DIV_GO;
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						idx_q[k_q] <= quot;
						iok_q[k_q] <= 1'b1;
						k_q        <= k_q + 1'b1;
						state_q    <= (k_q == 2'(SERIES - 1)) ? ST_UPDATE : ST_MUL_HI;
					end
				end
				ST_UPDATE: begin
					for (int k = 0; k < SERIES; k++) begin
						if (chg[k]) begin
							pok_q[uix][k] <= iok_q[k];
						end
					end
					state_q <= (chg != '0) ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_u_q     <= u_q;
						res_idx_q   <= idx_q;
						res_ok_q    <= iok_q;
						res_spot_q  <= spot_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign quote_stall     = (state_q != ST_IDLE);
	assign cfg_ready       = 1'b1;
	assign result_valid    = res_valid_q;
	assign out_underlying  = res_u_q;
	assign index_first     = res_idx_q[0];
	assign index_first_ok  = res_ok_q[0];
	assign index_second    = res_idx_q[1];
	assign index_second_ok = res_ok_q[1];
	assign index_third     = res_idx_q[2];
	assign index_third_ok  = res_ok_q[2];
	assign out_spot        = res_spot_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_STRIKES)) else $error("strike count beyond table size");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV) else $error("divider done outside wait");
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_EMIT)) else $error("result without emit");
`endif
endmodule

// ----- tb/sv/stvi_checker.sv -----
`timescale 1ns / 100ps

module stvi_checker
	import stvi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               quote_valid,
	input  logic               quote_stall,
	input  logic [UID_W-1:0]   underlying_id,
	input  logic               is_call,
	input  logic [PRICE_W-1:0] strike_price,
	input  logic [PRICE_W-1:0] spot_price,
	input  logic [VOL_W-1:0]   vol_first,
	input  logic               vol_first_ok,
	input  logic [VOL_W-1:0]   vol_second,
	input  logic               vol_second_ok,
	input  logic [VOL_W-1:0]   vol_third,
	input  logic               vol_third_ok,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic [UID_W-1:0]   out_underlying,
	input  logic [VOL_W-1:0]   index_first,
	input  logic               index_first_ok,
	input  logic [VOL_W-1:0]   index_second,
	input  logic               index_second_ok,
	input  logic [VOL_W-1:0]   index_third,
	input  logic               index_third_ok,
	input  logic [PRICE_W-1:0] out_spot,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [TOL_W-1:0]   cfg_data,
	output int                 fails,
	output int                 pending
);

	localparam int NU = NUM_UNDERLYINGS_DEF;
	localparam int MS = MAX_STRIKES_DEF;

	typedef struct {
		logic [UID_W-1:0]               uid;
		logic [SERIES-1:0][VOL_W-1:0]   idx;
		logic [SERIES-1:0]              idx_ok;
		logic [PRICE_W-1:0]             spot;
	} vix_t;

	vix_t index_q[$];

	logic [PRICE_W-1:0] strikes [NU][MS];
	logic [SERIES-1:0][VOL_W-1:0] call_v [NU][MS];
	logic [SERIES-1:0][VOL_W-1:0] put_v [NU][MS];
	logic [SERIES-1:0] call_ok [NU][MS];
	logic [SERIES-1:0] put_ok [NU][MS];
	int n_strikes [NU];
	logic [SERIES-1:0][VOL_W-1:0] last_idx [NU];
	logic [SERIES-1:0] last_ok [NU];
	logic [TOL_W-1:0] tolerance;

	assign pending = index_q.size();

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
		fails++;
	endtask

	task automatic store_side(input int u, input int p, input bit c,
			input logic [SERIES-1:0][VOL_W-1:0] v, input logic [SERIES-1:0] ok);
		for (int k = 0; k < SERIES; k++) begin
			if (c)
				call_v[u][p][k] = ok[k] ? v[k] : '0;
			else
				put_v[u][p][k] = ok[k] ? v[k] : '0;
		end
		if (c)
			call_ok[u][p] = ok;
		else
			put_ok[u][p] = ok;
	endtask

	task automatic interpolate_quote(input int u, input bit c, input logic [31:0] strike,
			input logic [31:0] spot, input logic [SERIES-1:0][VOL_W-1:0] v,
			input logic [SERIES-1:0] ok);
		int n, p, hi, lo;
		logic [63:0] span, d_hi, d_lo, a_hi, a_lo, num, q;
		logic [31:0] diff;
		vix_t r;
		bit any, ch;
		if (ok == '0)
			return;
		n = n_strikes[u];
		if (n == 0) begin
			strikes[u][0] = strike;
			call_v[u][0] = '0; put_v[u][0] = '0; call_ok[u][0] = '0; put_ok[u][0] = '0;
			store_side(u, 0, c, v, ok);
			n_strikes[u] = 1;
			return;
		end
		p = 0;
		while (p < n && strikes[u][p] < strike)
			p++;
		if (p < n && strikes[u][p] == strike) begin
			store_side(u, p, c, v, ok);
		end else if (n < MS) begin
			for (int i = n; i > p; i--) begin
				strikes[u][i] = strikes[u][i-1];
				call_v[u][i] = call_v[u][i-1];
				put_v[u][i] = put_v[u][i-1];
				call_ok[u][i] = call_ok[u][i-1];
				put_ok[u][i] = put_ok[u][i-1];
			end
			strikes[u][p] = strike;
			call_v[u][p] = '0; put_v[u][p] = '0; call_ok[u][p] = '0; put_ok[u][p] = '0;
			store_side(u, p, c, v, ok);
			n++;
			n_strikes[u] = n;
		end
		hi = 0;
		while (hi < n && strikes[u][hi] < spot)
			hi++;
		if (hi >= n || hi == 0)
			return;
		lo = hi - 1;
		span = {32'd0, strikes[u][hi]} - {32'd0, strikes[u][lo]};
		d_hi = {32'd0, spot} - {32'd0, strikes[u][lo]};
		d_lo = {32'd0, strikes[u][hi]} - {32'd0, spot};
		r.uid = UID_W'(u);
		r.spot = spot;
		any = 0;
		for (int k = 0; k < SERIES; k++) begin
			r.idx[k] = '0;
			r.idx_ok[k] = 0;
			if (call_ok[u][hi][k] && put_ok[u][hi][k] && call_ok[u][lo][k] && put_ok[u][lo][k]) begin
				a_hi = ({32'd0, call_v[u][hi][k]} + {32'd0, put_v[u][hi][k]}) >> 1;
				a_lo = ({32'd0, call_v[u][lo][k]} + {32'd0, put_v[u][lo][k]}) >> 1;
				num = a_hi * d_hi + a_lo * d_lo + (span >> 1);
				q = num / span;
				r.idx[k] = q[31:0];
				r.idx_ok[k] = 1;
			end
			if (last_ok[u][k] != r.idx_ok[k]) begin
				ch = 1;
			end else if (r.idx_ok[k]) begin
				diff = last_idx[u][k] > r.idx[k] ? last_idx[u][k] - r.idx[k]
					: r.idx[k] - last_idx[u][k];
				ch = diff > {16'd0, tolerance};
			end else begin
				ch = 0;
			end
			if (ch) begin
				last_idx[u][k] = r.idx[k];
				last_ok[u][k] = r.idx_ok[k];
				any = 1;
			end
		end
		if (any)
			index_q.push_back(r);
	endtask

	initial begin
		fails = 0;
		tolerance = TOL_RESET;
		for (int u = 0; u < NU; u++) begin
			n_strikes[u] = 0;
			last_ok[u] = '0;
			last_idx[u] = '0;
		end
	end

	always @(posedge clk) begin
		vix_t e;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (index_q.size() == 0) begin
					$display("unexpected result item at %0t", $time);
					fails++;
				end else begin
					e = index_q.pop_front();
					if (out_underlying !== e.uid) report("out_underlying", out_underlying, e.uid);
					if (index_first !== e.idx[0]) report("index_first", index_first, e.idx[0]);
					if (index_first_ok !== e.idx_ok[0])
						report("index_first_ok", index_first_ok, e.idx_ok[0]);
					if (index_second !== e.idx[1]) report("index_second", index_second, e.idx[1]);
					if (index_second_ok !== e.idx_ok[1])
						report("index_second_ok", index_second_ok, e.idx_ok[1]);
					if (index_third !== e.idx[2]) report("index_third", index_third, e.idx[2]);
					if (index_third_ok !== e.idx_ok[2])
						report("index_third_ok", index_third_ok, e.idx_ok[2]);
					if (out_spot !== e.spot) report("out_spot", out_spot, e.spot);
				end
			end
			if (cfg_valid && cfg_ready)
				tolerance = cfg_data;
			if (quote_valid && !quote_stall)
				interpolate_quote(int'(underlying_id), is_call, strike_price, spot_price,
					{vol_third, vol_second, vol_first},
					{vol_third_ok, vol_second_ok, vol_first_ok});
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import stvi_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;

	logic clk = 0;
	logic arst_n = 0;
	logic quote_valid = 0;
	logic quote_stall;
	logic [UID_W-1:0] underlying_id = '0;
	logic is_call = 0;
	logic [PRICE_W-1:0] strike_price = '0;
	logic [PRICE_W-1:0] spot_price = '0;
	logic [VOL_W-1:0] vol_first = '0, vol_second = '0, vol_third = '0;
	logic vol_first_ok = 0, vol_second_ok = 0, vol_third_ok = 0;
	logic result_valid;
	logic result_stall = 0;
	logic [UID_W-1:0] out_underlying;
	logic [VOL_W-1:0] index_first, index_second, index_third;
	logic index_first_ok, index_second_ok, index_third_ok;
	logic [PRICE_W-1:0] out_spot;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [TOL_W-1:0] cfg_data = '0;

	int fails, pending;
	bit quiet = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	strike_table_vol_interpolator_core dut (.*);

	stvi_checker chk (.*);

	always @(posedge clk) begin
		if (quiet) begin
			result_stall <= 0;
		end else if (stall_left == 0) begin
			stall_left <= $urandom_range(1, 14);
			result_stall <= ($urandom_range(0, 2) == 0);
		end else begin
			stall_left <= stall_left - 1;
		end
	end

	always @(posedge clk) begin
		if ((quote_valid && !quote_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_quote(input int u, input bit c, input logic [31:0] strike,
			input logic [31:0] spot, input logic [31:0] v1, input logic [31:0] v2,
			input logic [31:0] v3, input logic [2:0] ok);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			quote_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		quote_valid <= 1;
		underlying_id <= UID_W'(u);
		is_call <= c;
		strike_price <= strike;
		spot_price <= spot;
		vol_first <= v1;
		vol_second <= v2;
		vol_third <= v3;
		{vol_third_ok, vol_second_ok, vol_first_ok} <= ok;
		@(posedge clk);
		while (quote_stall)
			@(posedge clk);
	endtask

	task automatic settle;
		quote_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [TOL_W-1:0] value);
		cfg_valid <= 1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
	endtask

	function automatic logic [31:0] rand_vol();
		if ($urandom_range(0, 7) == 0)
			return $urandom;
		return 32'h0400_0000 + $urandom_range(0, 32'h0080_0000);
	endfunction

	task automatic random_quotes(input int count);
		int u, grid;
		logic [31:0] base, strike, spot;
		logic [2:0] ok;
		for (int i = 0; i < count; i++) begin
			u = $urandom_range(0, 7);
			base = 32'd100000 * (u + 1);
			grid = (u == 7) ? 60 : 12;
			strike = base + 100 * $urandom_range(0, grid);
			spot = base - 200 + $urandom_range(0, 100 * grid + 400);
			if ($urandom_range(0, 9) == 0) strike = $urandom;
			if ($urandom_range(0, 19) == 0) spot = $urandom;
			ok = 3'b111;
			for (int k = 0; k < 3; k++)
				if ($urandom_range(0, 9) == 0) ok[k] = 0;
			if ($urandom_range(0, 29) == 0) ok = 3'b000;
			send_quote(u, 1'($urandom_range(0, 1)), strike, spot, rand_vol(), rand_vol(),
				rand_vol(), ok);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_quote(1, 1, 32'd10000, 32'd15000, 32'h1, 32'h2, 32'h3, 3'b000);
		send_quote(1, 1, 32'd10000, 32'd15000, 32'h0400_0000, 32'h0500_0000, 32'h0600_0000, 3'b111);
		send_quote(1, 0, 32'd10000, 32'd15000, 32'h0420_0000, 32'h0510_0000, 32'h0610_0000, 3'b111);
		send_quote(1, 1, 32'd20000, 32'd15000, 32'h0800_0000, 32'h0900_0000, 32'h0a00_0000, 3'b111);
		send_quote(1, 0, 32'd20000, 32'd15000, 32'h0810_0000, 32'h0910_0000, 32'h0a10_0000, 3'b111);
		send_quote(1, 0, 32'd20000, 32'd15001, 32'h0810_0000, 32'h0910_0000, 32'h0a10_0000, 3'b111);
		send_quote(1, 0, 32'd20000, 32'd10000, 32'h0810_0000, 32'h0910_0000, 32'h0a10_0000, 3'b111);
		send_quote(1, 0, 32'd20000, 32'd20001, 32'h0810_0000, 32'h0910_0000, 32'h0a10_0000, 3'b111);
		send_quote(1, 0, 32'd20000, 32'd20000, 32'h0810_0000, 32'h0910_0000, 32'h0a10_0000, 3'b101);
		send_quote(1, 1, 32'd15000, 32'd12500, 32'h0600_0000, 32'h0, 32'h0700_0000, 3'b011);
		send_quote(1, 0, 32'd15000, 32'd12500, 32'h0610_0000, 32'h0610_0000, 32'h0710_0000, 3'b111);
		send_quote(2, 1, 32'h0, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 3'b111);
		send_quote(2, 0, 32'h0, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 3'b111);
		send_quote(2, 1, 32'hffff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h0, 3'b111);
		send_quote(2, 0, 32'hffff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h0, 3'b111);
		send_quote(2, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0, 32'hffff_ffff, 3'b111);
		send_quote(2, 1, 32'h7fff_ffff, 32'h0000_0001, 32'h0aaa_aaaa, 32'h0555_5555, 32'h0, 3'b111);
		send_quote(2, 0, 32'h7fff_ffff, 32'h0000_0000, 32'h0aaa_aaaa, 32'h0555_5555, 32'h0, 3'b111);
		send_quote(0, 1, 32'd500, 32'd500, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 3'b100);
		send_quote(0, 0, 32'd500, 32'd700, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 3'b111);
		settle();

		write_tolerance(16'd0);
		random_quotes(300);
		settle();
		write_tolerance(16'hffff);
		random_quotes(280);
		settle();
		write_tolerance(TOL_W'($urandom_range(0, 16'hffff)));
		random_quotes(250);
		quiet = 1;
		random_quotes(200);

		quote_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- strike_table_vol_interpolator_core.f -----
src/stvi_pkg.sv
src/stvi_ram.sv
src/stvi_div.sv
src/strike_table_vol_interpolator_core.sv
tb/sv/stvi_checker.sv
tb/sv/tb_top.sv
